// ===== hdl/key_value_line_parser_core_defines.svh =====
// Assertion macros shared by the key/value line parser RTL.
`ifndef KEY_VALUE_LINE_PARSER_CORE_DEFINES_SVH
`define KEY_VALUE_LINE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define KVLP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kvlp assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define KVLP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kvlp assertion failed");

`endif

// ===== hdl/kvlp_pkg.sv =====
// Shared constants, codes and helper functions of the key/value line parser.
package kvlp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned MAG_W  = 32;
    localparam int unsigned PROD_W = MAG_W + 4;

    localparam logic [MAG_W-1:0] KEY_MAG_CAP = 32'h8000_0000;
    localparam logic [MAG_W-1:0] KEY_POS_MAX = 32'h7FFF_FFFF;

    // Action codes of an input beat
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOL  = 1'b1;

    // Kind codes of an output beat
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    // Line status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_COMMA = 1'b1;

    // Characters
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

// ===== hdl/kvlp_in_if.sv =====
// Input channel of the key/value line parser: action and line byte.
interface kvlp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [kvlp_pkg::BYTE_W-1:0]   line_byte;

    modport source (output valid, output action, output line_byte, input ready);
    modport sink   (input valid, input action, input line_byte, output ready);
endinterface

// ===== hdl/kvlp_out_if.sv =====
// Output channel of the key/value line parser: value bytes and line results.
interface kvlp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [kvlp_pkg::BYTE_W-1:0]        value_byte;
    logic signed [kvlp_pkg::KEY_W-1:0]  key;
    logic                               status;

    modport source (output valid, output kind, output value_byte, output key,
                    output status, input ready);
    modport sink   (input valid, input kind, input value_byte, input key,
                    input status, output ready);
endinterface

// ===== hdl/kvlp_key_unit.sv =====
// Key arithmetic: decimal digit accumulate with saturation and signed key form.
module kvlp_key_unit (
    input  logic [kvlp_pkg::MAG_W-1:0]         i_mag,
    input  logic                               i_neg,
    input  logic [3:0]                         i_digit,
    output logic [kvlp_pkg::MAG_W-1:0]         o_mag_next,
    output logic signed [kvlp_pkg::KEY_W-1:0]  o_key
);

    logic [kvlp_pkg::PROD_W-1:0] w_sum;
    logic [kvlp_pkg::MAG_W-1:0]  w_pos;

    // mag * 10 + digit as (mag << 3) + (mag << 1) + digit
    assign w_sum = {1'b0, i_mag, 3'b000}
                 + {3'b000, i_mag, 1'b0}
                 + {{(kvlp_pkg::PROD_W-4){1'b0}}, i_digit};

    assign o_mag_next = (w_sum > {4'b0000, kvlp_pkg::KEY_MAG_CAP})
                      ? kvlp_pkg::KEY_MAG_CAP : w_sum[kvlp_pkg::MAG_W-1:0];

    assign w_pos = (i_mag > kvlp_pkg::KEY_POS_MAX) ? kvlp_pkg::KEY_POS_MAX : i_mag;

    assign o_key = i_neg ? $signed(32'd0 - i_mag) : $signed(w_pos);

endmodule

// ===== hdl/key_value_line_parser_core.sv =====
// Top level of the key/value line parser: per-line state and registered output beat.
// An output beat, if any, is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle, limited only by the single output register.
// Input ready stays high while the output register is empty or being drained.
// Reset (synchronous, active low) returns to the leading-space phase with a
// zero key and clears the output valid; no clearing pass is needed.
`include "key_value_line_parser_core_defines.svh"

module key_value_line_parser_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kvlp_in_if.sink       i_in,
    kvlp_out_if.source    o_out
);

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_DIGITS,
        PH_SEEK,
        PH_GAP,
        PH_VALUE,
        PH_TAIL,
        PH_DONE
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [kvlp_pkg::MAG_W-1:0]          r_key_mag, n_key_mag;
    logic                                r_key_neg, n_key_neg;
    logic [kvlp_pkg::BYTE_W-1:0]         r_delim, n_delim;

    logic                                r_out_valid, n_out_valid;
    logic                                r_kind, n_kind;
    logic [kvlp_pkg::BYTE_W-1:0]         r_value_byte, n_value_byte;
    logic signed [kvlp_pkg::KEY_W-1:0]   r_key, n_key;
    logic                                r_status, n_status;

    logic                                w_in_accept;
    logic [kvlp_pkg::MAG_W-1:0]          w_mag_digit;
    logic signed [kvlp_pkg::KEY_W-1:0]   w_key_final;
    logic                                w_line_status;
    logic [kvlp_pkg::BYTE_W-1:0]         w_b;
    logic                                w_eol_accept;
    logic                                w_line_clear;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_b         = i_in.line_byte;

    assign w_eol_accept = w_in_accept && (i_in.action == kvlp_pkg::ACT_EOL);
    assign w_line_clear = (r_phase == PH_SPACE) && (r_key_mag == '0) && !r_key_neg;

    kvlp_key_unit u_key (
        .i_mag      (r_key_mag),
        .i_neg      (r_key_neg),
        .i_digit    (w_b[3:0]),
        .o_mag_next (w_mag_digit),
        .o_key      (w_key_final)
    );

    assign w_line_status = (r_phase == PH_GAP || r_phase == PH_VALUE || r_phase == PH_TAIL)
                         ? kvlp_pkg::STATUS_OK : kvlp_pkg::STATUS_NO_COMMA;

    always_comb begin
        n_phase      = r_phase;
        n_key_mag    = r_key_mag;
        n_key_neg    = r_key_neg;
        n_delim      = r_delim;
        n_out_valid  = 1'b0;
        n_kind       = kvlp_pkg::KIND_VALUE;
        n_value_byte = kvlp_pkg::CH_NUL;
        n_key        = '0;
        n_status     = kvlp_pkg::STATUS_OK;

        if (i_in.action == kvlp_pkg::ACT_EOL) begin
            if (r_phase != PH_DONE) begin
                n_out_valid = 1'b1;
                n_kind      = kvlp_pkg::KIND_RESULT;
                n_key       = w_key_final;
                n_status    = w_line_status;
            end
            n_phase   = PH_SPACE;
            n_key_mag = '0;
            n_key_neg = 1'b0;
            n_delim   = kvlp_pkg::CH_NL;
        end else if (r_phase == PH_DONE) begin
            n_phase = PH_DONE;
        end else if (w_b == kvlp_pkg::CH_NUL) begin
            n_out_valid = 1'b1;
            n_kind      = kvlp_pkg::KIND_RESULT;
            n_key       = w_key_final;
            n_status    = w_line_status;
            n_phase     = PH_DONE;
        end else begin
            unique case (r_phase)
                PH_SPACE: begin
                    if (kvlp_pkg::is_space(w_b)) begin
                        n_phase = PH_SPACE;
                    end else if (w_b == kvlp_pkg::CH_PLUS || w_b == kvlp_pkg::CH_MINUS) begin
                        n_key_neg = (w_b == kvlp_pkg::CH_MINUS);
                        n_phase   = PH_DIGITS;
                    end else if (kvlp_pkg::is_digit(w_b)) begin
                        n_key_mag = w_mag_digit;
                        n_phase   = PH_DIGITS;
                    end else if (w_b == kvlp_pkg::CH_COMMA) begin
                        n_phase = PH_GAP;
                    end else begin
                        n_phase = PH_SEEK;
                    end
                end
                PH_DIGITS: begin
                    if (kvlp_pkg::is_digit(w_b)) begin
                        n_key_mag = w_mag_digit;
                    end else begin
                        n_phase = (w_b == kvlp_pkg::CH_COMMA) ? PH_GAP : PH_SEEK;
                    end
                end
                PH_SEEK: begin
                    if (w_b == kvlp_pkg::CH_COMMA) begin
                        n_phase = PH_GAP;
                    end
                end
                PH_GAP: begin
                    if (w_b == kvlp_pkg::CH_SPACE || w_b == kvlp_pkg::CH_TAB) begin
                        n_phase = PH_GAP;
                    end else if (w_b == kvlp_pkg::CH_SQUOTE || w_b == kvlp_pkg::CH_DQUOTE) begin
                        n_delim = w_b;
                        n_phase = PH_VALUE;
                    end else if (w_b == kvlp_pkg::CH_NL) begin
                        n_delim = kvlp_pkg::CH_NL;
                        n_phase = PH_TAIL;
                    end else begin
                        n_delim      = kvlp_pkg::CH_NL;
                        n_phase      = PH_VALUE;
                        n_out_valid  = 1'b1;
                        n_value_byte = w_b;
                    end
                end
                PH_VALUE: begin
                    if (w_b == r_delim) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_value_byte = w_b;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SPACE;
            r_key_mag   <= '0;
            r_key_neg   <= 1'b0;
            r_delim     <= kvlp_pkg::CH_NL;
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_phase     <= n_phase;
            r_key_mag   <= n_key_mag;
            r_key_neg   <= n_key_neg;
            r_delim     <= n_delim;
            r_out_valid <= n_out_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept && n_out_valid) begin
            r_kind       <= n_kind;
            r_value_byte <= n_value_byte;
            r_key        <= n_key;
            r_status     <= n_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_kind;
    assign o_out.value_byte = r_value_byte;
    assign o_out.key        = r_key;
    assign o_out.status     = r_status;

    `KVLP_ASSERT_NOW(a_mag_capped, 1'b1, r_key_mag <= kvlp_pkg::KEY_MAG_CAP)
    `KVLP_ASSERT_NOW(a_stall_only_when_full, !i_in.ready, r_out_valid && !o_out.ready)
    `KVLP_ASSERT_NEXT(a_eol_restarts, w_eol_accept, w_line_clear)
    `KVLP_ASSERT_NEXT(a_done_silent, w_in_accept && r_phase == PH_DONE, !r_out_valid)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the key/value line parser: directed lines, output stall, random lines.
module testbench;

    typedef enum logic [2:0] {
        LP_SPACE,
        LP_DIGITS,
        LP_SEEK,
        LP_GAP,
        LP_VALUE,
        LP_TAIL,
        LP_DONE
    } t_line_phase;

    typedef struct packed {
        logic                               kind;
        logic [kvlp_pkg::BYTE_W-1:0]        value_byte;
        logic signed [kvlp_pkg::KEY_W-1:0]  key;
        logic                               status;
    } t_out_beat;

    logic clk;
    logic rst_n;

    kvlp_in_if  in_ch ();
    kvlp_out_if out_ch ();

    key_value_line_parser_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_line_phase                  line_phase;
    logic [kvlp_pkg::MAG_W-1:0]   key_mag;
    logic                         key_neg;
    logic [kvlp_pkg::BYTE_W-1:0]  value_delim;

    t_out_beat   expected_beats[$];
    bit          idling = 1'b1;
    int unsigned hold_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned beats_sent = 0;
    int unsigned lines_sent = 0;
    int unsigned value_bytes_seen = 0;
    int unsigned line_results_seen = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("%0t: timeout with %0d beats still expected", $time, expected_beats.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void expect_beat(input t_out_beat b);
        expected_beats = {expected_beats, b};
    endfunction

    function automatic logic is_blank(input logic [kvlp_pkg::BYTE_W-1:0] b);
        case (b)
            kvlp_pkg::CH_SPACE, kvlp_pkg::CH_TAB, kvlp_pkg::CH_NL,
            kvlp_pkg::CH_VT, kvlp_pkg::CH_FF, kvlp_pkg::CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_numeral(input logic [kvlp_pkg::BYTE_W-1:0] b);
        return (b >= kvlp_pkg::CH_ZERO) && (b <= kvlp_pkg::CH_NINE);
    endfunction

    function automatic logic [kvlp_pkg::MAG_W-1:0] next_magnitude(
        input logic [kvlp_pkg::MAG_W-1:0]  mag,
        input logic [kvlp_pkg::BYTE_W-1:0] b
    );
        logic [63:0] prod;
        prod = {32'd0, mag} * 64'd10 + {56'd0, b - kvlp_pkg::CH_ZERO};
        return (prod > {32'd0, kvlp_pkg::KEY_MAG_CAP}) ? kvlp_pkg::KEY_MAG_CAP
                                                      : prod[kvlp_pkg::MAG_W-1:0];
    endfunction

    function automatic t_out_beat line_result();
        t_out_beat r;
        r.kind       = kvlp_pkg::KIND_RESULT;
        r.value_byte = '0;
        if (key_neg)
            r.key = -$signed(key_mag);
        else
            r.key = (key_mag > kvlp_pkg::KEY_POS_MAX) ? kvlp_pkg::KEY_POS_MAX : key_mag;
        r.status = (line_phase == LP_GAP || line_phase == LP_VALUE || line_phase == LP_TAIL) ?
                   kvlp_pkg::STATUS_OK : kvlp_pkg::STATUS_NO_COMMA;
        return r;
    endfunction

    function automatic t_out_beat value_beat(input logic [kvlp_pkg::BYTE_W-1:0] b);
        t_out_beat r;
        r.kind       = kvlp_pkg::KIND_VALUE;
        r.value_byte = b;
        r.key        = '0;
        r.status     = kvlp_pkg::STATUS_OK;
        return r;
    endfunction

    task automatic restart_line();
        line_phase  = LP_SPACE;
        key_mag     = '0;
        key_neg     = 1'b0;
        value_delim = kvlp_pkg::CH_NL;
    endtask

    task automatic predict_line_beat(input logic act, input logic [kvlp_pkg::BYTE_W-1:0] b);
        if (act == kvlp_pkg::ACT_EOL) begin
            if (line_phase != LP_DONE)
                expect_beat(line_result());
            restart_line();
            return;
        end
        if (line_phase == LP_DONE)
            return;
        if (b == kvlp_pkg::CH_NUL) begin
            expect_beat(line_result());
            line_phase = LP_DONE;
            return;
        end
        case (line_phase)
            LP_SPACE: begin
                if (is_blank(b)) begin
                end else if (b == kvlp_pkg::CH_PLUS || b == kvlp_pkg::CH_MINUS) begin
                    key_neg    = (b == kvlp_pkg::CH_MINUS);
                    line_phase = LP_DIGITS;
                end else if (is_numeral(b)) begin
                    key_mag    = next_magnitude(key_mag, b);
                    line_phase = LP_DIGITS;
                end else begin
                    line_phase = (b == kvlp_pkg::CH_COMMA) ? LP_GAP : LP_SEEK;
                end
            end
            LP_DIGITS: begin
                if (is_numeral(b))
                    key_mag = next_magnitude(key_mag, b);
                else
                    line_phase = (b == kvlp_pkg::CH_COMMA) ? LP_GAP : LP_SEEK;
            end
            LP_SEEK: begin
                if (b == kvlp_pkg::CH_COMMA)
                    line_phase = LP_GAP;
            end
            LP_GAP: begin
                if (b == kvlp_pkg::CH_SPACE || b == kvlp_pkg::CH_TAB) begin
                end else if (b == kvlp_pkg::CH_SQUOTE || b == kvlp_pkg::CH_DQUOTE) begin
                    value_delim = b;
                    line_phase  = LP_VALUE;
                end else begin
                    value_delim = kvlp_pkg::CH_NL;
                    if (b == kvlp_pkg::CH_NL) begin
                        line_phase = LP_TAIL;
                    end else begin
                        line_phase = LP_VALUE;
                        expect_beat(value_beat(b));
                    end
                end
            end
            LP_VALUE: begin
                if (b == value_delim)
                    line_phase = LP_TAIL;
                else
                    expect_beat(value_beat(b));
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_beat(input logic act, input logic [kvlp_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        if (idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.line_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        predict_line_beat(act, b);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(kvlp_pkg::ACT_BYTE, s[i]);
    endtask

    task automatic end_line(input logic [kvlp_pkg::BYTE_W-1:0] b);
        send_beat(kvlp_pkg::ACT_EOL, b);
        lines_sent++;
    endtask

    function automatic logic [kvlp_pkg::BYTE_W-1:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return kvlp_pkg::CH_SPACE;
            1: return kvlp_pkg::CH_TAB;
            2: return kvlp_pkg::CH_NL;
            3: return kvlp_pkg::CH_VT;
            4: return kvlp_pkg::CH_FF;
            default: return kvlp_pkg::CH_CR;
        endcase
    endfunction

    function automatic logic [kvlp_pkg::BYTE_W-1:0] pick_content();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic send_random_line();
        int unsigned n;
        int unsigned style;
        logic [kvlp_pkg::BYTE_W-1:0] quote;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) send_beat(kvlp_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
            end_line(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) send_beat(kvlp_pkg::ACT_BYTE, pick_blank());
        case ($urandom_range(0, 5))
            0: send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_PLUS);
            1, 2: send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_MINUS);
            default: begin
            end
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
        repeat (n)
            send_beat(kvlp_pkg::ACT_BYTE,
                      8'($urandom_range(kvlp_pkg::CH_ZERO, kvlp_pkg::CH_NINE)));
        if ($urandom_range(0, 7) == 0)
            send_beat(kvlp_pkg::ACT_BYTE, 8'($urandom_range(8'h61, 8'h7A)));
        if ($urandom_range(0, 9) != 0)
            send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_COMMA);
        repeat ($urandom_range(0, 2))
            send_beat(kvlp_pkg::ACT_BYTE,
                      $urandom_range(0, 1) ? kvlp_pkg::CH_SPACE : kvlp_pkg::CH_TAB);
        style = $urandom_range(0, 2);
        quote = (style == 1) ? kvlp_pkg::CH_SQUOTE : kvlp_pkg::CH_DQUOTE;
        if (style != 0)
            send_beat(kvlp_pkg::ACT_BYTE, quote);
        repeat ($urandom_range(0, 8)) send_beat(kvlp_pkg::ACT_BYTE, pick_content());
        if ($urandom_range(0, 3) != 0)
            send_beat(kvlp_pkg::ACT_BYTE, (style == 0) ? kvlp_pkg::CH_NL : quote);
        repeat ($urandom_range(0, 2)) send_beat(kvlp_pkg::ACT_BYTE, pick_content());
        if ($urandom_range(0, 11) == 0) begin
            send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_NUL);
            repeat ($urandom_range(0, 2))
                send_beat(kvlp_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
        end
        end_line(8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed_lines();
        send_text("12,ab");
        end_line(8'h00);
        send_text(" \t-7,'x\n'z");
        end_line(8'hFF);
        send_text("+,\"q");
        end_line(8'hA5);
        send_text("99999999999,v");
        end_line(8'h5A);
        send_text("-2147483649,\n");
        end_line(8'h00);
        send_text(",\t\"\"x");
        end_line(8'h00);
        send_text("5 ab");
        end_line(8'h00);
        send_text("7x,9\nz");
        end_line(8'h00);
        send_text("3,a");
        send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_NUL);
        send_text("b");
        end_line(8'hFF);
        send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_NUL);
        end_line(8'h00);
        end_line(8'h00);
        send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_VT);
        send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_FF);
        send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_CR);
        send_beat(kvlp_pkg::ACT_BYTE, kvlp_pkg::CH_NL);
        send_text("8,");
        send_beat(kvlp_pkg::ACT_BYTE, 8'hFF);
        send_beat(kvlp_pkg::ACT_BYTE, 8'h80);
        end_line(8'h00);
    endtask

    task automatic test_output_backpressure();
        bit saved;
        saved       = idling;
        idling      = 1'b0;
        hold_cycles = 60;
        repeat (5) begin
            send_text("4,abcdefghijkl");
            end_line(8'h00);
        end
        idling = saved;
    endtask

    task automatic test_random_lines(input int unsigned beat_count);
        int unsigned stop_at;
        stop_at = beats_sent + beat_count;
        while (beats_sent < stop_at)
            send_random_line();
    endtask

    task automatic test_unbroken_stream(input int unsigned beat_count);
        idling = 1'b0;
        test_random_lines(beat_count);
    endtask

    initial begin : receiver
        int unsigned n;
        forever begin
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end else if (idling && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic report_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (out_ch.kind == kvlp_pkg::KIND_RESULT)
                line_results_seen++;
            else
                value_bytes_seen++;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual kind %0d byte %02h",
                         $time, out_ch.kind, out_ch.value_byte);
                $display("%0t: unexpected beat, actual key %0d status %0d",
                         $time, out_ch.key, out_ch.status);
                mismatches++;
            end else begin
                want = expected_beats[0];
                expected_beats.delete(0);
                report_field("kind", longint'(want.kind), longint'(out_ch.kind));
                report_field("value_byte", longint'(want.value_byte),
                             longint'(out_ch.value_byte));
                report_field("key", longint'(want.key), longint'(out_ch.key));
                report_field("status", longint'(want.status), longint'(out_ch.status));
            end
        end
    end

    initial begin
        restart_line();
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= kvlp_pkg::ACT_BYTE;
        in_ch.line_byte <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lines();
        test_output_backpressure();
        test_random_lines(800);
        test_unbroken_stream(150);

        in_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d input beats over %0d lines: directed edge cases, a long output stall,",
                 beats_sent, lines_sent);
        $display("random and noise lines; checked %0d value bytes and %0d line results.",
                 value_bytes_seen, line_results_seen);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/kvlp_pkg.sv
hdl/kvlp_in_if.sv
hdl/kvlp_out_if.sv
hdl/kvlp_key_unit.sv
hdl/key_value_line_parser_core.sv
tb/sv/testbench.sv
